// ----- hw/rtl/lfu_pkg.sv -----
// Shared constants for the LFU cache table: field widths, opcodes and
// the reset value of the capacity register. No dependencies.
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

endpackage

// ----- hw/rtl/lfu_cache_table.sv -----
// LFU cache table with LRU tie-break, built around one entry memory.
// Depends on lfu_pkg.
//
// Each beat on the slave side is one get or put; each gives one result beat.
// A new item is accepted only once the last one is through. One pass over
// the entry memory looks up the key and picks the victim; after a get hit
// or an enabled put, a second pass rewrites the recency ranks and the
// target entry, and a put that fills a free slot then writes the new entry.
// Each pass handles one entry per cycle, because the memory has a single read
// and a single write port. Valid entries are always slots 0..F-1 (F = entries
// held), so reset needs no clearing pass. The result beat waits in an output
// register while the table is updated and the next item is taken. A result
// still waiting on the master side holds the following item in its result
// state.
module lfu_cache_table #(
  parameter int CAPACITY   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]   cfg_wr_data,  // capacity_in_use
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,      // key[31:0], value[63:32]
  input  logic [0:0]                  s_tuser,      // opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,      // read_value
  output logic [0:0]                  m_tuser       // hit
);
  import lfu_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > CFG_W) ? FW : CFG_W;
  localparam int CB = COUNT_BITS;
  localparam int EW = KEY_W + VAL_W + CB + AW;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_RES, ST_UPD, ST_INS} state_t;
  typedef enum logic [1:0] {MD_TOUCH, MD_EVICT, MD_INSERT} mode_t;

  state_t state;
  mode_t mode;
  logic [CFG_W-1:0] cap;
  logic [FW-1:0] fill;
  logic [FW-1:0] cnt;
  logic rd_v;
  logic [AW-1:0] rd_idx;
  op_t op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic found;
  logic [AW-1:0] f_idx;
  logic [VAL_W-1:0] f_val;
  logic [AW-1:0] f_rank;
  logic v_ok;
  logic [AW-1:0] v_idx;
  logic [CB-1:0] v_cnt;
  logic [AW-1:0] v_rank;
  logic [AW-1:0] tgt;
  logic [AW-1:0] tgt_rank;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [KEY_W-1:0] e_key;
  logic [VAL_W-1:0] e_val;
  logic [CB-1:0] e_cnt;
  logic [AW-1:0] e_rank;
  logic [CB-1:0] e_cnt_inc;
  logic more;
  logic ins_free;
  logic is_tgt;
  logic [AW-1:0] n_rank;
  logic [KEY_W-1:0] n_key;
  logic [VAL_W-1:0] n_val;
  logic [CB-1:0] n_cnt;
  logic out_free;
  logic res_upd;
  mode_t res_mode;

  assign {e_key, e_val, e_cnt, e_rank} = rd_data;
  assign e_cnt_inc = (e_cnt == {CB{1'b1}}) ? e_cnt : e_cnt + CB'(1);
  assign more = cnt < fill;
  assign ins_free = (CW'(fill) < CW'(cap)) && (CW'(fill) < CW'(CAPACITY));
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign res_upd = (op == OP_GET) ? found : (cap != '0);

  assign rd_en   = (state == ST_SCAN || state == ST_UPD) && more;
  assign rd_addr = cnt[AW-1:0];

  always_comb begin
    res_mode = MD_TOUCH;
    if (op == OP_PUT && !found) begin
      if (ins_free) begin
        res_mode = MD_INSERT;
      end else begin
        res_mode = MD_EVICT;
      end
    end
  end

  always_comb begin
    is_tgt = (mode != MD_INSERT) && (rd_idx == tgt);
    n_key  = e_key;
    n_val  = e_val;
    n_cnt  = e_cnt;
    n_rank = e_rank;
    if (mode == MD_INSERT) begin
      n_rank = e_rank + AW'(1);
    end else if (is_tgt) begin
      n_rank = '0;
      if (mode == MD_EVICT) begin
        n_key = key;
        n_val = val;
        n_cnt = CB'(1);
      end else begin
        n_cnt = e_cnt_inc;
        if (op == OP_PUT) begin
          n_val = val;
        end
      end
    end else if (e_rank < tgt_rank) begin
      n_rank = e_rank + AW'(1);
    end
    if (state == ST_INS) begin
      wr_en   = 1'b1;
      wr_addr = fill[AW-1:0];
      wr_data = {key, val, CB'(1), AW'(0)};
    end else begin
      wr_en   = (state == ST_UPD) && rd_v;
      wr_addr = rd_idx;
      wr_data = {n_key, n_val, n_cnt, n_rank};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cap      <= CAP_RESET;
      fill     <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      rd_v     <= 1'b0;
      found    <= 1'b0;
      v_ok     <= 1'b0;
      mode     <= MD_TOUCH;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (state == ST_RES && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op    <= op_t'(s_tuser[0]);
            key   <= s_tdata[31:0];
            val   <= s_tdata[63:32];
            cnt   <= '0;
            rd_v  <= 1'b0;
            found <= 1'b0;
            v_ok  <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_v) begin
            if (e_key == key) begin
              found  <= 1'b1;
              f_idx  <= rd_idx;
              f_val  <= e_val;
              f_rank <= e_rank;
            end
            if (!v_ok || e_cnt < v_cnt || (e_cnt == v_cnt && e_rank > v_rank)) begin
              v_ok   <= 1'b1;
              v_idx  <= rd_idx;
              v_cnt  <= e_cnt;
              v_rank <= e_rank;
            end
          end
          if (more) begin
            cnt    <= cnt + FW'(1);
            rd_v   <= 1'b1;
            rd_idx <= cnt[AW-1:0];
          end else begin
            rd_v  <= 1'b0;
            state <= ST_RES;
          end
        end
        ST_RES: begin
          if (out_free) begin
            m_tuser[0] <= found;
            m_tdata    <= (op == OP_GET && found) ? f_val : '0;
            cnt        <= '0;
            rd_v       <= 1'b0;
            mode       <= res_mode;
            if (res_mode == MD_EVICT) begin
              tgt      <= v_idx;
              tgt_rank <= v_rank;
            end else begin
              tgt      <= f_idx;
              tgt_rank <= f_rank;
            end
            state <= res_upd ? ST_UPD : ST_IDLE;
          end
        end
        ST_UPD: begin
          if (more) begin
            cnt    <= cnt + FW'(1);
            rd_v   <= 1'b1;
            rd_idx <= cnt[AW-1:0];
          end else begin
            rd_v  <= 1'b0;
            state <= (mode == MD_INSERT) ? ST_INS : ST_IDLE;
          end
        end
        ST_INS: begin
          fill  <= fill + FW'(1);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_lfu_cache_table.sv -----
// Testbench for lfu_cache_table: drives gets and puts over the stream ports and
// checks each result beat against an in-bench LFU/LRU table model.
// Depends on lfu_pkg and the lfu_cache_table RTL.
module tb_lfu_cache_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int SLOTS = 32;
  localparam int COUNT_MAX = 65535;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic        hit;
    logic [31:0] rd;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0] m_tuser;

  lfu_cache_table dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // table model
  logic [5:0]  cap_reg = CAP_RESET;
  bit          tv [SLOTS];
  logic [31:0] tkey [SLOTS];
  logic [31:0] tval [SLOTS];
  int          tcnt [SLOTS];
  int          trank [SLOTS];
  int          fill;
  lookup_t     pending_results[$];

  int errors = 0;
  int sent = 0;
  int checked = 0;
  int hits = 0;
  int evicts = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  function automatic void bump_recent(int s);
    for (int i = 0; i < SLOTS; i++)
      if (tv[i] && i != s && trank[i] < trank[s]) trank[i]++;
    trank[s] = 0;
  endfunction

  function automatic void place_entry(int s, logic [31:0] k, logic [31:0] v);
    for (int i = 0; i < SLOTS; i++)
      if (tv[i]) trank[i]++;
    tv[s] = 1;
    tkey[s] = k;
    tval[s] = v;
    tcnt[s] = 1;
    trank[s] = 0;
  endfunction

  function automatic lookup_t apply_op(op_t op, logic [31:0] k, logic [31:0] v);
    int found;
    int free_slot;
    int victim;
    int cap;
    lookup_t r;
    found = -1;
    free_slot = -1;
    victim = -1;
    cap = (cap_reg < SLOTS) ? cap_reg : SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (tv[i]) begin
        if (tkey[i] == k) found = i;
        if (victim < 0 || tcnt[i] < tcnt[victim] ||
            (tcnt[i] == tcnt[victim] && trank[i] > trank[victim])) victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    r.hit = (found >= 0);
    r.rd = '0;
    if (op == OP_GET) begin
      if (found >= 0) begin
        r.rd = tval[found];
        if (tcnt[found] < COUNT_MAX) tcnt[found]++;
        bump_recent(found);
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        tval[found] = v;
        if (tcnt[found] < COUNT_MAX) tcnt[found]++;
        bump_recent(found);
      end else if (fill < cap && free_slot >= 0) begin
        fill++;
        place_entry(free_slot, k, v);
      end else if (victim >= 0) begin
        evicts++;
        for (int i = 0; i < SLOTS; i++)
          if (tv[i] && trank[i] > trank[victim]) trank[i]--;
        tv[victim] = 0;
        place_entry(victim, k, v);
      end
    end
    return r;
  endfunction

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    lookup_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: hit=%0b value=%h", $time, m_tuser, m_tdata);
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (e.hit) hits++;
        if (m_tuser[0] !== e.hit || m_tdata !== e.rd) begin
          errors++;
          $display("%0t mismatch: expected hit=%0b value=%h, actual hit=%0b value=%h",
                   $time, e.hit, e.rd, m_tuser, m_tdata);
        end
      end
    end
    if (hold_off) begin
      m_tready <= 1'b0;
      hold_cycles++;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted in cycles
  task automatic hold_receiver(int n);
    hold_off = 1;
    repeat (n) @(posedge clk);
    hold_off = 0;
  endtask

  task automatic send_item(op_t op, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_op(op, k, v));
    sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_capacity(logic [5:0] c);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = c;
  endtask

  function automatic logic [31:0] pick_key(int span);
    return ($urandom_range(9) == 0) ? $urandom() : 32'hFFFF_FFF0 + $urandom_range(span);
  endfunction

  task automatic test_directed();
    send_item(OP_GET, 32'h8000_0000, 32'h0);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h0, 32'h0);
    send_item(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_PUT, 32'h0, 32'h5555_AAAA);
    send_item(OP_GET, 32'h0, 32'h0);
    send_item(OP_GET, 32'h1, 32'h0);
  endtask

  task automatic test_small_capacity();
    write_capacity(6'd2);
    for (int i = 0; i < 6; i++) send_item(OP_PUT, 32'h100 + i, $urandom());
    send_item(OP_GET, 32'h105, 0);
    send_item(OP_PUT, 32'h200, 32'hA5A5_A5A5);
    send_item(OP_GET, 32'h104, 0);
    write_capacity(6'd0);
    send_item(OP_PUT, 32'h105, 32'hDEAD_BEEF);
    send_item(OP_PUT, 32'h300, 32'h1);
    send_item(OP_GET, 32'h105, 0);
  endtask

  task automatic test_random(int n, int span);
    for (int i = 0; i < n; i++)
      send_item(op_t'(1'($urandom_range(1))), pick_key(span), $urandom());
  endtask

  task automatic test_hot_keys();
    write_capacity(6'd4);
    for (int i = 0; i < 4; i++) send_item(OP_PUT, 32'h40 + i, i);
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 40; i++) send_item(OP_GET, 32'h40 + (i % 2), 0);
    send_item(OP_PUT, 32'h50, 7);
    send_item(OP_PUT, 32'h51, 8);
    send_item(OP_GET, 32'h40, 0);
    send_item(OP_GET, 32'h41, 0);
  endtask

  task automatic test_backpressure();
    fork
      hold_receiver(600);
      for (int i = 0; i < 12; i++) send_item(OP_PUT, pick_key(20), $urandom());
    join
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_capacity();
    write_capacity(6'd63);
    idle_pct = 0;  stall_pct = 0;  test_random(300, 40);
    idle_pct = 54; stall_pct = 0;  test_random(250, 40);
    write_capacity(6'd7);
    idle_pct = 0;  stall_pct = 54; test_random(250, 20);
    write_capacity(6'd32);
    idle_pct = 34; stall_pct = 34; test_random(250, 60);
    write_capacity(6'd1);
    idle_pct = 0;  stall_pct = 0;  test_random(150, 6);
    test_backpressure();
    test_hot_keys();
    drain_results();
    $display("Ran %0d items (%0d hits, %0d evictions), %0d results checked.",
             sent, hits, evicts, checked);
    $display("Capacities 0..63, hot-key eviction order, hold-off of %0d cycles.",
             hold_cycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- lfu_cache_table.f -----
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cache_table.sv
tb/sv/tb_lfu_cache_table.sv
